// File: hdl/wtsc_pkg.sv
// Shared types and token codes for the spoken weight announcer.
// No dependencies; imported by wtsc_emit and weight_to_spoken_clip_sequence.
`timescale 1ns / 1ps

package wtsc_pkg;

	typedef logic [4:0] clip_t;
	typedef logic [3:0] digit_t;

	// Spoken-clip token codes; digits 0-9 are the digit value itself
	localparam clip_t TOK_ZERO    = 5'd0;
	localparam clip_t TOK_TEN     = 5'd10;
	localparam clip_t TOK_HUNDRED = 5'd11;
	localparam clip_t TOK_LINH    = 5'd12;
	localparam clip_t TOK_MUOI    = 5'd13;
	localparam clip_t TOK_LAM     = 5'd14;
	localparam clip_t TOK_MOT     = 5'd15;
	localparam clip_t TOK_COMMA   = 5'd16;
	localparam clip_t TOK_KILO    = 5'd17;

	// Decimal digits of one weight: kilogram part and gram part
	typedef struct packed {
		digit_t kh;
		digit_t kt;
		digit_t ku;
		logic   kzero;
		digit_t fh;
		digit_t ft;
		digit_t fu;
		logic   fnz;
	} digits_t;

endpackage

// File: hdl/weight_to_spoken_clip_sequence.sv
// Top level of the spoken weight announcer: input register, grams-to-digits
// pipeline and the token emitter. Depends on wtsc_pkg and wtsc_emit.
`timescale 1ns / 1ps

// Usage
// Input channel: grams with grams_valid / grams_stall. A weight transfers at a
// clock edge with grams_valid high and grams_stall low. Values above 999999
// are read as 999999.
// Output channel: clip and last_clip with clip_valid / clip_stall. Each weight
// gives 2 to 12 tokens, one per transfer, with last_clip high on the final
// kilogram word.
// Path: the first token of a weight passes the input register, six more stages
// for the decimal split, one for the emitter's slot list, then the emitter's
// output register.
// Throughput: one token per cycle while clip_stall is low; the next weight's
// list loads in the cycle the last token of the previous one leaves, so
// sequences follow each other with no gap. The emitter sets the rate.
// Stall: while clip_stall is high the output holds; the digit pipeline keeps
// filling until its stages are full and then raises grams_stall.
// Reset: arst_n clears all valid flags and the pending token list; no
// announcement survives reset.

module weight_to_spoken_clip_sequence (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [19:0]     grams,
	input  logic            grams_valid,
	output logic            grams_stall,
	output wtsc_pkg::clip_t clip,
	output logic            last_clip,
	output logic            clip_valid,
	input  logic            clip_stall
);
	import wtsc_pkg::*;

	localparam logic [19:0] MaxGrams = 20'd999999;
	// floor(g / 1000) = (g * ceil(2^30 / 1000)) >> 30 for g below 2^20
	localparam logic [20:0] KgRecip  = 21'd1073742;
	localparam logic [5:0]  HundMul  = 6'd41;   // (v * 41) >> 12 = v / 100, v < 1000
	localparam logic [7:0]  TensMul  = 8'd205;  // (r * 205) >> 11 = r / 10, r < 100

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en1, en2, en3, en4, en5, en6, en7;
	logic emit_ready;

	logic [19:0] g_s1;
	logic [19:0] g_s2;
	logic [9:0]  kg_s2;
	logic [9:0]  kg_s3, fr_s3;
	logic [9:0]  kg_s4, fr_s4;
	digit_t      kh_s4, fh_s4;
	digit_t      kh_s5, fh_s5;
	logic [6:0]  kr_s5, frr_s5;
	logic        kzero_s5, fnz_s5;
	digit_t      kh_s6, fh_s6, kt_s6, ft_s6;
	logic [6:0]  kr_s6, frr_s6;
	logic        kzero_s6, fnz_s6;
	digits_t     dig_s7;

	logic [40:0] kg_prod;
	logic [19:0] kg_thou;
	logic [15:0] kh_prod, fh_prod;
	logic [14:0] kt_prod, ft_prod;
	logic [9:0]  kh_hund, fh_hund;
	logic [6:0]  kt_ten, ft_ten;

	// Stage enables: a stage loads when empty or when the next one loads
	assign en7 = !valid_s7 || emit_ready;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign grams_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= grams_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	// Datapath arithmetic between stages
	assign kg_prod = 41'(g_s1) * 41'(KgRecip);
	assign kg_thou = 20'(kg_s2) * 20'd1000;
	assign kh_prod = 16'(kg_s3) * 16'(HundMul);
	assign fh_prod = 16'(fr_s3) * 16'(HundMul);
	assign kh_hund = 10'(kh_s4) * 10'd100;
	assign fh_hund = 10'(fh_s4) * 10'd100;
	assign kt_prod = 15'(kr_s5) * 15'(TensMul);
	assign ft_prod = 15'(frr_s5) * 15'(TensMul);
	assign kt_ten  = 7'(kt_s6) * 7'd10;
	assign ft_ten  = 7'(ft_s6) * 7'd10;

	// Payload stages: saturate, split kg / grams, then hundreds, tens, units
	always_ff @(posedge clk) begin
		if (en1) begin
			g_s1 <= (grams > MaxGrams) ? MaxGrams : grams;
		end
		if (en2) begin
			g_s2  <= g_s1;
			kg_s2 <= kg_prod[39:30];
		end
		if (en3) begin
			kg_s3 <= kg_s2;
			fr_s3 <= 10'(g_s2 - kg_thou);
		end
		if (en4) begin
			kg_s4 <= kg_s3;
			fr_s4 <= fr_s3;
			kh_s4 <= kh_prod[15:12];
			fh_s4 <= fh_prod[15:12];
		end
		if (en5) begin
			kh_s5    <= kh_s4;
			fh_s5    <= fh_s4;
			kr_s5    <= 7'(kg_s4 - kh_hund);
			frr_s5   <= 7'(fr_s4 - fh_hund);
			kzero_s5 <= (kg_s4 == 10'd0);
			fnz_s5   <= (fr_s4 != 10'd0);
		end
		if (en6) begin
			kh_s6    <= kh_s5;
			fh_s6    <= fh_s5;
			kr_s6    <= kr_s5;
			frr_s6   <= frr_s5;
			kt_s6    <= kt_prod[14:11];
			ft_s6    <= ft_prod[14:11];
			kzero_s6 <= kzero_s5;
			fnz_s6   <= fnz_s5;
		end
		if (en7) begin
			dig_s7.kh    <= kh_s6;
			dig_s7.kt    <= kt_s6;
			dig_s7.ku    <= 4'(kr_s6 - kt_ten);
			dig_s7.kzero <= kzero_s6;
			dig_s7.fh    <= fh_s6;
			dig_s7.ft    <= ft_s6;
			dig_s7.fu    <= 4'(frr_s6 - ft_ten);
			dig_s7.fnz   <= fnz_s6;
		end
	end

	wtsc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.dig_valid  (valid_s7),
		.dig        (dig_s7),
		.dig_ready  (emit_ready),
		.clip_valid (clip_valid),
		.clip_stall (clip_stall),
		.clip       (clip),
		.last_clip  (last_clip)
	);

	// The final token of every announcement is the kilogram word, and only it
	a_last_is_kilo: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && last_clip |-> clip == TOK_KILO)
		else $error("last_clip on a token other than the unit word");

	a_kilo_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		clip_valid && clip == TOK_KILO |-> last_clip)
		else $error("unit word without last_clip");

	// Input side only backs up when the first and the last stage hold an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		grams_stall |-> valid_s1 && valid_s7)
		else $error("input stalled with an empty pipeline");

	// A digit set in the last stage while the emitter is ready is taken at that
	// edge: the stage then is empty or holds the item of the stage before it
	a_emit_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s7 && emit_ready |=> !valid_s7 || $past(valid_s6))
		else $error("digit stage kept a stale item");

endmodule

// File: hdl/wtsc_emit.sv
// Token emitter: turns one set of decimal digits into the spoken-clip sequence
// and hands it out one token per transfer. Depends on wtsc_pkg.
`timescale 1ns / 1ps

module wtsc_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dig_valid,
	input  wtsc_pkg::digits_t dig,
	output logic              dig_ready,
	output logic              clip_valid,
	input  logic              clip_stall,
	output wtsc_pkg::clip_t   clip,
	output logic              last_clip
);
	import wtsc_pkg::*;

	localparam int SlotN = 14;
	localparam int IdxW  = $clog2(SlotN);

	function automatic clip_t dig_tok(digit_t d);
		return {1'b0, d};
	endfunction

	function automatic clip_t tens_tok(digit_t t);
		return (t == 4'd1) ? TOK_TEN : dig_tok(t);
	endfunction

	function automatic clip_t unit_tok(digit_t t, digit_t u);
		clip_t r;
		if (t != 4'd0 && u == 4'd5) begin
			r = TOK_LAM;
		end else if (t > 4'd1 && u == 4'd1) begin
			r = TOK_MOT;
		end else begin
			r = dig_tok(u);
		end
		return r;
	endfunction

	logic [SlotN-1:0] mask_q;
	clip_t            tok_q [SlotN];
	logic             out_valid_q;
	clip_t            clip_q;
	logic             last_q;

	logic [SlotN-1:0] new_mask;
	clip_t            new_tok [SlotN];
	logic [SlotN-1:0] pick_hot;
	logic [IdxW-1:0]  pick_idx;
	logic [SlotN-1:0] mask_left;
	logic             has_tok;
	logic             take;
	logic             pop;

	// Lay out every possible word in a fixed slot; the mask marks the spoken ones
	always_comb begin
		new_tok[0]  = dig_tok(dig.kh);
		new_mask[0] = dig.kh != 4'd0;
		new_tok[1]  = TOK_HUNDRED;
		new_mask[1] = dig.kh != 4'd0;
		new_tok[2]  = TOK_LINH;
		new_mask[2] = dig.kh != 4'd0 && dig.kt == 4'd0 && dig.ku != 4'd0;
		new_tok[3]  = tens_tok(dig.kt);
		new_mask[3] = dig.kt != 4'd0;
		new_tok[4]  = TOK_MUOI;
		new_mask[4] = dig.kt > 4'd1;
		new_tok[5]  = dig.kzero ? TOK_ZERO : unit_tok(dig.kt, dig.ku);
		new_mask[5] = dig.kzero || dig.ku != 4'd0;
		new_tok[6]  = TOK_COMMA;
		new_mask[6] = dig.fnz;
		// leading gram digit: the hundreds digit, or a spoken zero
		new_tok[7]  = dig_tok(dig.fh);
		new_mask[7] = dig.fnz;
		new_tok[8]  = (dig.fh != 4'd0) ? TOK_HUNDRED : TOK_ZERO;
		new_mask[8] = dig.fnz && (dig.fh != 4'd0 || dig.ft == 4'd0);
		new_tok[9]  = TOK_LINH;
		new_mask[9] = dig.fh != 4'd0 && dig.ft == 4'd0 && dig.fu != 4'd0;
		new_tok[10]  = tens_tok(dig.ft);
		new_mask[10] = dig.ft != 4'd0;
		new_tok[11]  = TOK_MUOI;
		new_mask[11] = dig.ft > 4'd1;
		new_tok[12]  = unit_tok(dig.ft, dig.fu);
		new_mask[12] = dig.fu != 4'd0;
		new_tok[13]  = TOK_KILO;
		new_mask[13] = 1'b1;
	end

	// Pick the lowest pending slot
	always_comb begin
		pick_idx = '0;
		for (int i = SlotN - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick_idx = IdxW'(i);
			end
		end
	end

	assign pick_hot  = mask_q & (~mask_q + 1'b1);
	assign has_tok   = |mask_q;
	assign take      = !out_valid_q || !clip_stall;
	assign pop       = take && has_tok;
	assign mask_left = pop ? (mask_q & ~pick_hot) : mask_q;
	assign dig_ready = (mask_left == '0);

	// Slot mask and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mask_q <= (dig_valid && dig_ready) ? new_mask : mask_left;
			if (take) begin
				out_valid_q <= has_tok;
			end
		end
	end

	// Token payload: load a fresh list, advance the output on transfer
	always_ff @(posedge clk) begin
		if (dig_valid && dig_ready) begin
			tok_q <= new_tok;
		end
		if (take) begin
			clip_q <= tok_q[pick_idx];
			last_q <= (pick_idx == IdxW'(SlotN - 1));
		end
	end

	assign clip_valid = out_valid_q;
	assign clip       = clip_q;
	assign last_clip  = last_q;

endmodule
